@@ hw/rtl/mewd_pkg.sv @@
// Package for the encoded-word decoder: result entry, word state and
// character constants, plus the hex and base64 symbol lookups.
// No dependencies.
package mewd_pkg;

  localparam logic [7:0] CHR_US  = 8'h5F;
  localparam logic [7:0] CHR_EQ  = 8'h3D;
  localparam logic [7:0] CHR_SP  = 8'h20;
  localparam logic [7:0] CHR_TAB = 8'h09;
  localparam logic [7:0] CHR_CR  = 8'h0D;
  localparam logic [7:0] CHR_LF  = 8'h0A;
  localparam logic [7:0] CHR_PLS = 8'h2B;
  localparam logic [7:0] CHR_SL  = 8'h2F;
  localparam logic [5:0] B64_PLS = 6'd62;
  localparam logic [5:0] B64_SL  = 6'd63;
  localparam int unsigned MAX_RES = 3;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       word_error;
    logic       word_last;
  } entry_t;

  typedef struct packed {
    logic [1:0]  pend_cnt;
    logic [7:0]  hex_char;
    logic [11:0] acc;
    logic [3:0]  bit_cnt;
    logic        stopped;
    logic        err;
  } word_state_t;

  // {valid, value}
  function automatic logic [4:0] hex_of(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  // {valid, value}
  function automatic logic [6:0] b64_of(input logic [7:0] c);
    logic [6:0] r;
    r = '0;
    if (c >= 8'h41 && c <= 8'h5A) r = {1'b1, 6'(c - 8'h41)};
    else if (c >= 8'h61 && c <= 8'h7A) r = {1'b1, 6'(c - 8'h47)};
    else if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 6'(c + 8'h04)};
    else if (c == CHR_PLS) r = {1'b1, B64_PLS};
    else if (c == CHR_SL) r = {1'b1, B64_SL};
    return r;
  endfunction

endpackage

@@ hw/rtl/mewd_in_if.sv @@
// Input channel: one encoded byte per request, with a last marker.
// Standalone, no dependencies.
interface mewd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source (output valid, in_byte, in_last, input ready);
  modport sink (input valid, in_byte, in_last, output ready);
endinterface

@@ hw/rtl/mewd_out_if.sv @@
// Result channel: one decoded result per request.
// Standalone, no dependencies.
interface mewd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       word_error;
  logic       word_last;
  modport source (output valid, out_byte, has_byte, word_error, word_last, input ready);
  modport sink (input valid, out_byte, has_byte, word_error, word_last, output ready);
endinterface

@@ hw/rtl/mewd_cfg_if.sv @@
// Configuration write channel carrying the decode mode register.
// Standalone, no dependencies.
interface mewd_cfg_if;
  logic valid;
  logic ready;
  logic decode_mode;
  modport source (output valid, decode_mode, input ready);
  modport sink (input valid, decode_mode, output ready);
endinterface

@@ hw/rtl/mewd_step.sv @@
// Per-byte decode logic: Q and base64 rules, next word state, up to three results.
// Depends on mewd_pkg.
module mewd_step
  import mewd_pkg::*;
(
  input  logic        mode,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  input  word_state_t st,
  output word_state_t st_nxt,
  output logic [1:0]  res_n,
  output entry_t      res [MAX_RES]
);

  logic [4:0]  hx;
  logic [4:0]  hh;
  logic [6:0]  bv;
  logic [1:0]  pfx_n;
  logic [7:0]  p0;
  logic [7:0]  p1;
  logic        run_plain;
  logic        pl_has;
  logic [7:0]  pl_byte;
  logic [11:0] acc_n;
  logic [11:0] acc_sh;
  logic [3:0]  bc6;
  logic [1:0]  n_raw;
  logic [1:0]  n_fin;
  logic [7:0]  bytes [MAX_RES];
  word_state_t ns;

  always_comb begin
    ns = st;
    if (ns.pend_cnt == 2'd3) ns.pend_cnt = 2'd0;
    hx = hex_of(in_byte);
    hh = hex_of(st.hex_char);
    bv = b64_of(in_byte);
    pfx_n = 2'd0;
    p0 = '0;
    p1 = '0;
    run_plain = 1'b0;
    pl_has = 1'b0;
    pl_byte = '0;
    acc_n = '0;
    acc_sh = '0;
    bc6 = '0;
    if (!mode) begin
      case (ns.pend_cnt)
        2'd1: begin
          if (hx[4] && !in_last) begin
            ns.pend_cnt = 2'd2;
            ns.hex_char = in_byte;
          end else begin
            ns.pend_cnt = 2'd0;
            pfx_n = 2'd1;
            p0 = CHR_EQ;
            run_plain = 1'b1;
          end
        end
        2'd2: begin
          ns.pend_cnt = 2'd0;
          if (hx[4]) begin
            pl_has = 1'b1;
            pl_byte = {hh[3:0], hx[3:0]};
          end else begin
            pfx_n = 2'd2;
            p0 = CHR_EQ;
            p1 = st.hex_char;
            run_plain = 1'b1;
          end
        end
        default: run_plain = 1'b1;
      endcase
      if (run_plain) begin
        if (in_byte == CHR_US) begin
          pl_has = 1'b1;
          pl_byte = CHR_SP;
        end else if (in_byte == CHR_EQ) begin
          if (!in_last) ns.pend_cnt = 2'd1;
        end else begin
          pl_has = 1'b1;
          pl_byte = in_byte;
        end
      end
    end else if (!ns.stopped) begin
      if (in_byte == CHR_SP || in_byte == CHR_TAB || in_byte == CHR_CR
          || in_byte == CHR_LF) begin
        ns.stopped = ns.stopped;
      end else if (in_byte == CHR_EQ) begin
        ns.stopped = 1'b1;
      end else if (!bv[6]) begin
        ns.err = 1'b1;
        ns.stopped = 1'b1;
      end else begin
        acc_n = {ns.acc[5:0], bv[5:0]};
        ns.acc = acc_n;
        bc6 = ns.bit_cnt + 4'd6;
        if (bc6 >= 4'd8) begin
          ns.bit_cnt = bc6 - 4'd8;
          acc_sh = acc_n >> ns.bit_cnt;
          pl_has = 1'b1;
          pl_byte = acc_sh[7:0];
        end else begin
          ns.bit_cnt = bc6;
        end
      end
    end

    bytes[0] = '0;
    bytes[1] = '0;
    bytes[2] = '0;
    case (pfx_n)
      2'd1: begin
        bytes[0] = p0;
        bytes[1] = pl_byte;
      end
      2'd2: begin
        bytes[0] = p0;
        bytes[1] = p1;
        bytes[2] = pl_byte;
      end
      default: bytes[0] = pl_byte;
    endcase
    n_raw = pfx_n + {1'b0, pl_has};
    n_fin = (in_last && n_raw == 2'd0) ? 2'd1 : n_raw;

    for (int i = 0; i < MAX_RES; i++) begin
      res[i].out_byte   = (2'(i) < n_raw) ? bytes[i] : 8'd0;
      res[i].has_byte   = 2'(i) < n_raw;
      res[i].word_error = ns.err;
      res[i].word_last  = in_last && (2'(i) == n_fin - 2'd1);
    end
    res_n = n_fin;
    st_nxt = in_last ? '0 : ns;
  end

endmodule

@@ hw/rtl/mime_encoded_word_decoder_top.sv @@
// Encoded-word (Q / base64) decoder top level.
// The first result of a byte is registered and offered in the cycle after its request is taken.
// Throughput: one byte per cycle while the result port is ready; a byte that yields several results
// holds the input until its last result is left, as the port sends one result per cycle from a three-entry buffer.
// Reset (synchronous, rst_n low): mode selects Q, word state and result buffer clear.
// Depends on mewd_pkg, the mewd channel interfaces and mewd_step.
module mime_encoded_word_decoder_top
  import mewd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  mewd_in_if.sink    in_ch,
  mewd_out_if.source out_ch,
  mewd_cfg_if.sink   cfg_ch
);

  logic        mode_r;
  word_state_t st_r;
  word_state_t st_nxt;
  logic [1:0]  cnt_r;
  logic [1:0]  cnt_nxt;
  entry_t      ent_r [MAX_RES];
  entry_t      ent_nxt [MAX_RES];
  entry_t      res [MAX_RES];
  logic [1:0]  res_n;
  logic        pop;
  logic        take;

  mewd_step u_step (
    .mode    (mode_r),
    .in_byte (in_ch.in_byte),
    .in_last (in_ch.in_last),
    .st      (st_r),
    .st_nxt  (st_nxt),
    .res_n   (res_n),
    .res     (res)
  );

  assign cfg_ch.ready = rst_n;
  assign out_ch.valid = cnt_r != 2'd0;
  assign out_ch.out_byte   = ent_r[0].out_byte;
  assign out_ch.has_byte   = ent_r[0].has_byte;
  assign out_ch.word_error = ent_r[0].word_error;
  assign out_ch.word_last  = ent_r[0].word_last;

  assign pop = out_ch.valid && out_ch.ready;
  assign in_ch.ready = rst_n && ((cnt_r == 2'd0) || (cnt_r == 2'd1 && out_ch.ready));
  assign take = in_ch.valid && in_ch.ready;

  always_comb begin
    ent_nxt = ent_r;
    cnt_nxt = cnt_r;
    if (take) begin
      ent_nxt = res;
      cnt_nxt = res_n;
    end else if (pop) begin
      ent_nxt[0] = ent_r[1];
      ent_nxt[1] = ent_r[2];
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
    if (!rst_n) begin
      mode_r <= 1'b0;
      st_r <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (take) st_r <= st_nxt;
      if (cfg_ch.valid) mode_r <= cfg_ch.decode_mode;
    end
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Testbench for mime_encoded_word_decoder_top: directed and random Q and base64 words
// run through the decoder, with every result checked against an in-bench decoder model.
// Depends on mewd_pkg and the mewd_in_if, mewd_out_if and mewd_cfg_if interfaces.
module tb;
  import mewd_pkg::*;

  localparam int IDLE_PCT       = 16;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES  = 4;
  localparam int MAX_REPORTS    = 10;

  localparam logic [1:0] Q_NONE     = 2'd0;
  localparam logic [1:0] Q_EQ       = 2'd1;
  localparam logic [1:0] Q_EQ_DIGIT = 2'd2;
  localparam logic [1:0] Q_BAD      = 2'd3;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } enc_byte_t;

  logic clk;
  logic rst_n;

  mewd_in_if  in_ch ();
  mewd_out_if out_ch ();
  mewd_cfg_if cfg_ch ();

  mime_encoded_word_decoder_top DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  enc_byte_t  encoded_pending[$];
  entry_t     decoded_due[$];
  entry_t     step_out[$];
  logic [7:0] word_text[$];
  enc_byte_t  req_now;
  entry_t     due;
  int         queued_count = 0;
  int         bad_results  = 0;
  bit         calm         = 1'b0;
  bit         rx_hold_go   = 1'b0;
  logic       rx_stall     = 1'b0;

  logic        mode_b  = 1'b0;
  logic [1:0]  q_held  = Q_NONE;
  logic [7:0]  q_digit = '0;
  logic [11:0] b_acc   = '0;
  logic [3:0]  b_bits  = '0;
  logic        b_stop  = 1'b0;
  logic        b_err   = 1'b0;

  function automatic void add_char(input logic [7:0] c);
    word_text.insert(word_text.size(), c);
  endfunction

  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, c[3:0]};
    if (c >= "a" && c <= "f") return {1'b1, 4'(c[3:0] + 4'd9)};
    if (c >= "A" && c <= "F") return {1'b1, 4'(c[3:0] + 4'd9)};
    return 5'd0;
  endfunction

  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return {1'b1, 6'(c - "A")};
    if (c >= "a" && c <= "z") return {1'b1, 6'(c - "a" + 8'd26)};
    if (c >= "0" && c <= "9") return {1'b1, 6'(c - "0" + 8'd52)};
    if (c == CHR_PLS) return {1'b1, B64_PLS};
    if (c == CHR_SL) return {1'b1, B64_SL};
    return 7'd0;
  endfunction

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    if (v < 6'd26) return 8'("A" + v);
    if (v < 6'd52) return 8'("a" + v - 26);
    if (v < 6'd62) return 8'("0" + v - 52);
    return (v == B64_PLS) ? CHR_PLS : CHR_SL;
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == CHR_SP || c == CHR_TAB || c == CHR_CR || c == CHR_LF;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    if (v < 4'd10) return 8'("0" + v);
    return 8'(($urandom_range(0, 1) ? "a" : "A") + v - 8'd10);
  endfunction

  function automatic logic [7:0] non_hex();
    logic [7:0] c;
    logic [4:0] nib;
    do begin
      c = 8'($urandom_range(0, 255));
      nib = nibble_of(c);
    end while (nib[4]);
    return c;
  endfunction

  function automatic void emit(input logic [7:0] v);
    entry_t e;
    e = '0;
    e.out_byte = v;
    e.has_byte = 1'b1;
    if (step_out.size() < MAX_RES) step_out.insert(step_out.size(), e);
  endfunction

  function automatic void q_literal(input logic [7:0] c, input logic last);
    if (c == CHR_US) begin
      emit(CHR_SP);
    end else if (c == CHR_EQ) begin
      if (!last) q_held = Q_EQ;
    end else begin
      emit(c);
    end
  endfunction

  task automatic predict_decoded(input logic [7:0] c, input logic last);
    logic [4:0] nib;
    logic [4:0] held_nib;
    logic [6:0] sx;
    entry_t     e;
    int         k;
    step_out.delete();
    if (q_held == Q_BAD) q_held = Q_NONE;
    if (!mode_b) begin
      nib = nibble_of(c);
      case (q_held)
        Q_EQ: begin
          if (nib[4] && !last) begin
            q_digit = c;
            q_held = Q_EQ_DIGIT;
          end else begin
            q_held = Q_NONE;
            emit(CHR_EQ);
            q_literal(c, last);
          end
        end
        Q_EQ_DIGIT: begin
          q_held = Q_NONE;
          held_nib = nibble_of(q_digit);
          if (nib[4]) begin
            emit({held_nib[3:0], nib[3:0]});
          end else begin
            emit(CHR_EQ);
            emit(q_digit);
            q_literal(c, last);
          end
        end
        default: begin
          q_held = Q_NONE;
          q_literal(c, last);
        end
      endcase
    end else if (!b_stop && !is_blank(c)) begin
      if (c == CHR_EQ) begin
        b_stop = 1'b1;
      end else begin
        sx = sextet_of(c);
        if (!sx[6]) begin
          b_err = 1'b1;
          b_stop = 1'b1;
        end else begin
          b_acc = {b_acc[5:0], sx[5:0]};
          b_bits = b_bits + 4'd6;
          if (b_bits >= 4'd8) begin
            b_bits = b_bits - 4'd8;
            emit(8'(b_acc >> b_bits));
          end
        end
      end
    end
    if (last && step_out.size() == 0) begin
      e = '0;
      step_out.insert(step_out.size(), e);
    end
    for (k = 0; k < step_out.size(); k++) begin
      e = step_out[k];
      e.word_error = b_err;
      e.word_last = last && (k == step_out.size() - 1);
      decoded_due.insert(decoded_due.size(), e);
    end
    if (last) begin
      q_held = Q_NONE;
      q_digit = '0;
      b_acc = '0;
      b_bits = '0;
      b_stop = 1'b0;
      b_err = 1'b0;
    end
  endtask

  task automatic add_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) add_char(s[i]);
  endtask

  task automatic push_word(input bit close);
    enc_byte_t it;
    int        i;
    for (i = 0; i < word_text.size(); i++) begin
      it.code = word_text[i];
      it.last = close && (i == word_text.size() - 1);
      encoded_pending.insert(encoded_pending.size(), it);
    end
    queued_count += word_text.size();
    word_text.delete();
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (encoded_pending.size() != 0 || in_ch.valid || decoded_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(input logic m);
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.decode_mode <= m;
    do @(posedge clk); while (!cfg_ch.ready);
    mode_b = m;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic gen_q_word();
    int n;
    int pick;
    n = $urandom_range(1, 8);
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        add_char(8'($urandom_range(0, 255)));
      end else if (pick < 65) begin
        add_char(CHR_US);
      end else if (pick < 88) begin
        add_char(CHR_EQ);
        add_char(hex_digit(4'($urandom_range(0, 15))));
        add_char(hex_digit(4'($urandom_range(0, 15))));
      end else if (pick < 94) begin
        add_char(CHR_EQ);
        add_char(non_hex());
      end else begin
        add_char(CHR_EQ);
        add_char(hex_digit(4'($urandom_range(0, 15))));
        add_char(non_hex());
      end
    end
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      add_char(CHR_EQ);
    end else if (pick < 25) begin
      add_char(CHR_EQ);
      add_char(hex_digit(4'($urandom_range(0, 15))));
    end
    push_word(1'b1);
  endtask

  task automatic add_b_symbol(input logic [7:0] c);
    logic [7:0] bad;
    logic [6:0] sx;
    if ($urandom_range(0, 99) < 12) begin
      case ($urandom_range(0, 3))
        0: add_char(CHR_SP);
        1: add_char(CHR_TAB);
        2: add_char(CHR_CR);
        default: add_char(CHR_LF);
      endcase
    end
    if ($urandom_range(0, 99) < 3) begin
      do begin
        bad = 8'($urandom_range(0, 255));
        sx = sextet_of(bad);
      end while (sx[6] || is_blank(bad) || bad == CHR_EQ);
      add_char(bad);
    end
    add_char(c);
  endtask

  task automatic gen_b_word();
    logic [7:0]  raw[6];
    logic [23:0] grp;
    int          n;
    int          i;
    int          s;
    int          take;
    bit          padded;
    n = $urandom_range(1, 6);
    foreach (raw[j]) raw[j] = 8'($urandom_range(0, 255));
    padded = $urandom_range(0, 99) < 70;
    for (i = 0; i < n; i += 3) begin
      take = (n - i < 3) ? n - i : 3;
      grp = {raw[i], (take > 1) ? raw[i + 1] : 8'h00, (take > 2) ? raw[i + 2] : 8'h00};
      for (s = 0; s <= take; s++) add_b_symbol(sextet_char(grp[23 - 6 * s -: 6]));
      if (padded) repeat (3 - take) add_b_symbol(CHR_EQ);
    end
    if ($urandom_range(0, 99) < 20) begin
      add_char(CHR_EQ);
      repeat ($urandom_range(1, 3)) add_char(8'($urandom_range(0, 255)));
    end
    push_word(1'b1);
  endtask

  task automatic gen_noise_word();
    repeat ($urandom_range(1, 4)) add_char(8'($urandom_range(0, 255)));
    push_word(1'b1);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    wait (rx_hold_go);
    @(posedge clk);
    rx_stall <= 1'b1;
    repeat (RX_HOLD_CYCLES) @(posedge clk);
    rx_stall <= 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_decoded(in_ch.in_byte, in_ch.in_last);
      if (!in_ch.valid || in_ch.ready) begin
        if (encoded_pending.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          req_now = encoded_pending.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.in_byte <= req_now.code;
          in_ch.in_last <= req_now.last;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (decoded_due.size() == 0) begin
          bad_results++;
          if (bad_results <= MAX_REPORTS)
            $display("%0t: unexpected result byte %02h has %0b err %0b last %0b", $time,
                     out_ch.out_byte, out_ch.has_byte, out_ch.word_error, out_ch.word_last);
        end else begin
          due = decoded_due.pop_front();
          if (out_ch.out_byte !== due.out_byte || out_ch.has_byte !== due.has_byte ||
              out_ch.word_error !== due.word_error || out_ch.word_last !== due.word_last) begin
            bad_results++;
            if (bad_results <= MAX_REPORTS)
              $display("%0t: got byte %02h has %0b err %0b last %0b, want %02h %0b %0b %0b",
                       $time, out_ch.out_byte, out_ch.has_byte, out_ch.word_error,
                       out_ch.word_last, due.out_byte, due.has_byte, due.word_error,
                       due.word_last);
          end
        end
      end
      out_ch.ready <= !rx_stall && (calm || $urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  initial begin
    int p;
    int target;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.in_byte = '0;
    in_ch.in_last = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.decode_mode = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Q mode out of reset: hex escape, trailing equals, literal equals, short escapes
    add_text("=4a");
    push_word(1'b1);
    add_text("=");
    push_word(1'b1);
    add_text("=z_");
    push_word(1'b1);
    add_text("=F");
    push_word(1'b1);
    add_text("=A_");
    push_word(1'b1);
    add_char(8'h00);
    add_char(8'hFF);
    push_word(1'b1);

    // switch modes in the middle of a word; each mode keeps its own state
    add_text("=4");
    push_word(1'b0);
    set_mode(1'b1);
    add_text("QQ");
    push_word(1'b0);
    set_mode(1'b0);
    add_text("1");
    push_word(1'b1);

    // base64: whitespace, stop on padding with leftover bits, invalid symbols
    set_mode(1'b1);
    add_text("\r\nQ\tU=Z");
    push_word(1'b1);
    add_text("Q*A");
    push_word(1'b1);
    add_char(8'hFF);
    push_word(1'b1);

    for (p = 0; p < 8; p++) begin
      set_mode(p[0]);
      calm = (p == 2);
      if (p == 5) rx_hold_go = 1'b1;
      target = queued_count + 30;
      while (queued_count < target) begin
        if ($urandom_range(0, 99) < 12) gen_noise_word();
        else if (mode_b) gen_b_word();
        else gen_q_word();
      end
    end

    wait_drained();
    calm = 1'b0;
    repeat (10) @(posedge clk);
    if (decoded_due.size() != 0) begin
      bad_results += decoded_due.size();
      $display("%0d decoded results never arrived", decoded_due.size());
    end
    if (bad_results == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
